// ===== sv/clook_disk_request_scheduler_macros.svh =====
// Assertion macros for the scheduler RTL.
`ifndef CLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define CLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Checked on every clock edge outside reset.
`define CLOOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CLOOK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/clook_pkg.sv =====
`timescale 1ns / 1ps

package clook_pkg;

  // Geometry and queue sizing.
  localparam int QUEUE_DEPTH       = 64;
  localparam int SECTORS_PER_TRACK = 16;
  localparam int MAX_TRACKS        = 1024;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TRK_W   = 10;
  localparam int TCFG_W  = 11;
  localparam int SEC_W   = 4;
  localparam int SCNT_W  = 8;
  localparam int RQ_W    = 6;
  localparam int OP_W    = 2;
  // Sector addresses up to the end of the largest span, with headroom.
  localparam int SPAN_W  = $clog2(MAX_TRACKS * SECTORS_PER_TRACK + SECTORS_PER_TRACK + 256) + 1;

  // Request type codes.
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_type_t;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  // One queued request.
  typedef struct packed {
    logic [RQ_W-1:0]   requester;
    logic [OP_W-1:0]   op;
    logic [TRK_W-1:0]  track;
    logic [SEC_W-1:0]  first;
    logic [SCNT_W-1:0] count;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic insert;
    logic remove;
    logic occupied;
    logic after_cursor;
    logic at_cursor;
  } cell_ctl_t;

endpackage

// ===== sv/clook_disk_request_scheduler.sv =====
`timescale 1ns / 1ps
// An accepted transaction's result is loaded into the output register.
// Throughput: one enqueue or dispatch per cycle when not stalled; cells shift entries
// in parallel, and a new transaction is taken in the cycle the previous result leaves.
// Reset (synchronous, rst_n low) empties the queue, clears the cursor and sets the
// track count to zero; entry contents are not cleared and are never read unoccupied.
module clook_disk_request_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [clook_pkg::TCFG_W-1:0]  cfg_disk_tracks,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [clook_pkg::RQ_W-1:0]    in_requester,
  input  logic [clook_pkg::OP_W-1:0]    in_op_kind,
  input  logic [clook_pkg::TRK_W-1:0]   in_track,
  input  logic [clook_pkg::SEC_W-1:0]   in_first_sector,
  input  logic [clook_pkg::SCNT_W-1:0]  in_sector_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [clook_pkg::RQ_W-1:0]    out_served_requester,
  output logic [clook_pkg::OP_W-1:0]    out_served_op,
  output logic [clook_pkg::TRK_W-1:0]   out_served_track,
  output logic [clook_pkg::SEC_W-1:0]   out_served_first_sector,
  output logic [clook_pkg::SCNT_W-1:0]  out_served_sector_count,
  output logic [clook_pkg::CNT_W-1:0]   out_queue_count
);
  import clook_pkg::*;

  `include "clook_disk_request_scheduler_macros.svh"

  // Control state.
  logic [CNT_W-1:0]  count_r,  count_nxt;
  logic [IDX_W-1:0]  cur_r,    cur_nxt;
  logic              cset_r,   cset_nxt;
  logic [TCFG_W-1:0] tracks_r;
  logic              out_valid_r, out_valid_nxt;

  // Result register.
  status_t           status_r, status_nxt;
  entry_t            served_r, served_nxt;
  logic [CNT_W-1:0]  qcount_r;

  // Cell row signals.
  entry_t                 new_entry;
  entry_t                 cell_entry [QUEUE_DEPTH];
  entry_t                 cell_pick  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le_vec;
  entry_t                 picked;

  logic              accept, is_enq, op_ok, range_ok, full, has_entries;
  logic              do_insert, do_remove;
  logic [IDX_W-1:0]  c_eff;
  logic [CNT_W-1:0]  count_dec;
  logic [TCFG_W-1:0] tracks_eff;
  logic [SPAN_W-1:0] span_end, span_limit;
  op_t               op_in;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_enq    = (in_req_type == REQ_ENQ);
  assign op_in     = op_t'(in_op_kind);

  // Range check against the configured geometry.
  assign tracks_eff = (tracks_r > TCFG_W'(MAX_TRACKS)) ? TCFG_W'(MAX_TRACKS) : tracks_r;
  assign span_end   = SPAN_W'(in_track) * SPAN_W'(SECTORS_PER_TRACK)
                    + SPAN_W'(in_first_sector) + SPAN_W'(in_sector_count);
  assign span_limit = SPAN_W'(tracks_eff) * SPAN_W'(SECTORS_PER_TRACK);
  assign range_ok   = (TCFG_W'(in_track) < tracks_eff)
                   && (SPAN_W'(in_first_sector) < SPAN_W'(SECTORS_PER_TRACK))
                   && (span_end <= span_limit);

  always_comb begin
    case (op_in)
      OP_READ, OP_WRITE: op_ok = range_ok;
      OP_QUERY:          op_ok = 1'b1;
      default:           op_ok = 1'b0;
    endcase
  end

  // The entry to insert; a query carries no geometry.
  always_comb begin
    new_entry.requester = in_requester;
    new_entry.op        = in_op_kind;
    if (op_in == OP_QUERY) begin
      new_entry.track = '0;
      new_entry.first = '0;
      new_entry.count = '0;
    end else begin
      new_entry.track = in_track;
      new_entry.first = in_first_sector;
      new_entry.count = in_sector_count;
    end
  end

  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign has_entries = (count_r != '0);
  assign do_insert   = accept && is_enq && op_ok && !full;
  assign do_remove   = accept && !is_enq && has_entries;
  assign count_dec   = count_r - CNT_W'(1);
  // A cleared or stale cursor serves the lowest entry.
  assign c_eff       = (!cset_r || ({1'b0, cur_r} >= count_r)) ? '0 : cur_r;

  // Row of cells, each wired to its neighbors.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    left_e, right_e;
    logic      left_l;

    assign ctl.insert       = do_insert;
    assign ctl.remove       = do_remove;
    assign ctl.occupied     = (CNT_W'(gi) < count_r);
    assign ctl.after_cursor = (CNT_W'(gi) >= {1'b0, c_eff});
    assign ctl.at_cursor    = (CNT_W'(gi) == {1'b0, c_eff});

    if (gi == 0) begin : g_first
      assign left_e = new_entry;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[gi-1];
      assign left_l = le_vec[gi-1];
    end

    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[gi+1];
    end

    clook_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_le     (left_l),
      .entry       (cell_entry[gi]),
      .le          (le_vec[gi]),
      .pick        (cell_pick[gi])
    );
  end

  // Only the cursor cell drives a nonzero pick.
  always_comb begin
    picked = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      picked = picked | cell_pick[i];
    end
  end

  // Next queue, cursor and result.
  always_comb begin
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    cset_nxt      = cset_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    served_nxt    = served_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      served_nxt    = '0;
      if (is_enq) begin
        if (!op_ok) begin
          status_nxt = ST_INVALID;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          count_nxt  = count_r + CNT_W'(1);
          // The cursor follows its entry when the insert lands at or before it.
          if (cset_r && !le_vec[cur_r]) begin
            cur_nxt = cur_r + IDX_W'(1);
          end
        end
      end else if (!has_entries) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_DONE;
        served_nxt = picked;
        count_nxt  = count_dec;
        if (count_dec == '0) begin
          cset_nxt = 1'b0;
          cur_nxt  = '0;
        end else begin
          cset_nxt = 1'b1;
          cur_nxt  = ({1'b0, c_eff} >= count_dec) ? '0 : c_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cur_r       <= '0;
      cset_r      <= 1'b0;
      tracks_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      cset_r      <= cset_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tracks_r <= cfg_disk_tracks;
      end
    end
  end

  // Result payload; loaded with each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      served_r <= served_nxt;
      qcount_r <= count_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = status_r;
  assign out_served_requester    = served_r.requester;
  assign out_served_op           = served_r.op;
  assign out_served_track        = served_r.track;
  assign out_served_first_sector = served_r.first;
  assign out_served_sector_count = served_r.count;
  assign out_queue_count         = qcount_r;

  // Queue bookkeeping checks.
  `CLOOK_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "entry count exceeds queue depth")
  `CLOOK_ASSERT(a_cursor_inside, cset_r |-> ({1'b0, cur_r} < count_r), "cursor beyond last entry")
  `CLOOK_ASSERT(a_cursor_cleared, !cset_r |-> (cur_r == '0), "cleared cursor not at zero")
  `CLOOK_ASSERT(a_remove_count, do_remove |=> (count_r == $past(count_dec)), "dispatch miscounted")
  `CLOOK_ASSERT(a_result_follows, accept |=> out_valid_r, "accepted transaction left no result")

endmodule

// ===== sv/clook_cell.sv =====
`timescale 1ns / 1ps

module clook_cell (
  input  logic                clk,
  input  clook_pkg::cell_ctl_t ctl,
  input  clook_pkg::entry_t   new_entry,
  input  clook_pkg::entry_t   left_entry,
  input  clook_pkg::entry_t   right_entry,
  input  logic                left_le,
  output clook_pkg::entry_t   entry,
  output logic                le,
  output clook_pkg::entry_t   pick
);
  import clook_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // This cell holds an entry that sorts at or before the new request.
  assign le    = ctl.occupied && (entry_r.track <= new_entry.track);
  assign entry = entry_r;
  assign pick  = ctl.at_cursor ? entry_r : '0;

  // Insert shifts the tail to the right; remove closes the gap from the right.
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert && !le) begin
      entry_nxt = left_le ? new_entry : left_entry;
    end else if (ctl.remove && ctl.after_cursor) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
